>>> rtl/dzv_pkg.sv
// ============================================================================
// dzv_pkg
// Shared types and constants for the delta/zigzag varint column encoder.
// ============================================================================
package dzv_pkg;

    localparam int GROUP_BITS = 7;
    localparam int SR_W       = 5 * GROUP_BITS;

    localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7F;
    localparam logic [7:0]            CONT_BIT   = 8'h80;

    typedef struct packed {
        logic accept;
        logic step;
        logic last;
        logic next_varint;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic ovf;
        logic full;
        logic more;
    } sts_t;

endpackage

>>> rtl/dzv_ctrl.sv
// ============================================================================
// dzv_ctrl
// Sequencer: accepts one item, then steps out its result bytes one per cycle while the output register is free.
// ============================================================================
module dzv_ctrl
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_kind,
    output logic        in_ready,
    input  dzv_pkg::sts_t sts,
    output dzv_pkg::cmd_t cmd
);
    import dzv_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_VALUE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       stop;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        stop       = sts.ovf || sts.full || (!sts.more && state_reg == ST_VALUE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = in_kind ? ST_VALUE : ST_COUNT;
                end
            end
            ST_COUNT, ST_VALUE:
            begin
                if (sts.out_free)
                begin
                    cmd.step        = 1'b1;
                    cmd.last        = stop;
                    cmd.next_varint = (state_reg == ST_COUNT) && !sts.ovf
                                      && !sts.full && !sts.more;
                    if (stop)
                        state_next = ST_IDLE;
                    else if (cmd.next_varint)
                        state_next = ST_VALUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/dzv_datapath.sv
// ============================================================================
// dzv_datapath
// Zigzag/delta formation, varint shift register, byte position and result
// register.
// ============================================================================
module dzv_datapath
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    input  logic          in_kind,
    input  logic [31:0]   in_value,
    input  logic [31:0]   in_count,
    input  dzv_pkg::cmd_t cmd,
    output dzv_pkg::sts_t sts,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          out_byte_valid,
    output logic          out_last,
    output logic          out_status,
    output logic [31:0]   out_bytes_written
);
    import dzv_pkg::*;

    logic [31:0]     capacity_reg;
    logic [31:0]     prev_reg;
    logic [31:0]     pos_reg;
    logic            ovf_reg;
    logic [SR_W-1:0] sr_reg;
    logic [31:0]     zz_reg;

    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_bv_reg;
    logic            out_last_reg;
    logic            out_status_reg;
    logic [31:0]     out_bw_reg;

    logic [32:0]     delta;
    logic [33:0]     delta_zz;
    logic [31:0]     value_zz;
    logic            fail;
    logic [31:0]     pos_inc;

    assign delta    = {in_value[31], in_value} - {prev_reg[31], prev_reg};
    assign delta_zz = {delta, 1'b0} ^ {34{delta[32]}};
    assign value_zz = {in_value[30:0], 1'b0} ^ {32{in_value[31]}};
    assign pos_inc  = pos_reg + 32'd1;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.ovf      = ovf_reg;
    assign sts.full     = (pos_reg >= capacity_reg);
    assign sts.more     = (sr_reg[SR_W-1:GROUP_BITS] != '0);
    assign fail         = sts.ovf || sts.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= 32'hFFFF_FFFF;
            prev_reg      <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (cmd.accept)
            begin
                prev_reg <= in_value;
                if (!in_kind)
                begin
                    pos_reg <= '0;
                    ovf_reg <= 1'b0;
                end
            end
            else if (cmd.step)
            begin
                if (fail)
                    ovf_reg <= 1'b1;
                else
                    pos_reg <= pos_inc;
            end
            if (cmd.step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            zz_reg <= value_zz;
            if (!in_kind)
                sr_reg <= {{(SR_W-32){1'b0}}, in_count};
            else
                sr_reg <= {{(SR_W-34){1'b0}}, delta_zz};
        end
        else if (cmd.step && !fail)
        begin
            if (cmd.next_varint)
                sr_reg <= {{(SR_W-32){1'b0}}, zz_reg};
            else
                sr_reg <= sr_reg >> GROUP_BITS;
        end
        if (cmd.step)
        begin
            out_last_reg <= cmd.last;
            if (fail)
            begin
                out_byte_reg   <= '0;
                out_bv_reg     <= 1'b0;
                out_status_reg <= 1'b1;
                out_bw_reg     <= pos_reg;
            end
            else
            begin
                out_byte_reg   <= {1'b0, sr_reg[GROUP_BITS-1:0] & GROUP_MASK}
                                  | (sts.more ? CONT_BIT : 8'h00);
                out_bv_reg     <= 1'b1;
                out_status_reg <= 1'b0;
                out_bw_reg     <= pos_inc;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign out_byte_valid    = out_bv_reg;
    assign out_last          = out_last_reg;
    assign out_status        = out_status_reg;
    assign out_bytes_written = out_bw_reg;

endmodule

>>> rtl/delta_zigzag_varint_encoder.sv
// ============================================================================
// delta_zigzag_varint_encoder
// Column encoder: count and first value, then zigzag deltas, as varints.
// ============================================================================
// An item is accepted and its results are then stepped out one per cycle while
// the output register is free, since the varint shift register hands one 7-bit
// group to the output register at each step: a following value gives 1 to 5
// bytes, a column start a count and a first value, up to 5 bytes each. A result
// left waiting in the output register stalls stepping; the next item is taken
// as soon as the last result of the current one is in the output register.
// Capacity is checked before each byte; an overflow gives one status transfer
// in place of the byte, and later values give one status transfer each until
// a new column starts.
module delta_zigzag_varint_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] value, [63:32] count
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] bytes_written
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] status
    output logic        m_tlast
);
    import dzv_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dzv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dzv_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_kind           (s_tuser),
        .in_value          (s_tdata[31:0]),
        .in_count          (s_tdata[63:32]),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_byte          (m_tdata[7:0]),
        .out_byte_valid    (m_tuser[0]),
        .out_last          (m_tlast),
        .out_status        (m_tuser[1]),
        .out_bytes_written (m_tdata[39:8])
    );

endmodule
